@@ rtl/lrf_pkg.sv @@
`timescale 1ns / 1ps

package lrf_pkg;

    // Fixed field widths
    localparam int PIX_BITS       = 12;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUF_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUF_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUF_PRESENT = 2'd2;

    // Configuration reset values
    localparam logic [PIX_BITS-1:0] RESET_BUF_WIDTH  = 12'd626;
    localparam logic [PIX_BITS-1:0] RESET_BUF_HEIGHT = 12'd288;

    // Command queue between front and generator
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam logic [QUEUE_PTR_BITS:0] QUEUE_FULL = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

    // Rectangle sides, drawn in this order
    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    typedef enum logic [1:0] {
        MODE_LINE = 2'd0,
        MODE_RECT = 2'd1,
        MODE_FILL = 2'd2,
        MODE_STEP = 2'd3
    } lrf_mode_t;

    // Generator sequencer: idle/stepping, then the segment load states
    typedef enum logic [1:0] {
        GEN_IDLE  = 2'd0,
        GEN_SEG   = 2'd1,
        GEN_DELTA = 2'd2,
        GEN_MAJOR = 2'd3
    } lrf_gen_state_t;

    // Head of the command queue
    typedef struct packed {
        logic      valid;
        lrf_mode_t mode;
        logic      fill_empty;
    } lrf_head_t;

    // One generated point, already clipped
    typedef struct packed {
        logic                  we;
        logic [PIX_BITS-1:0]   x;
        logic [PIX_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } lrf_point_t;

    // Frame buffer configuration
    typedef struct packed {
        logic [PIX_BITS-1:0] width;
        logic [PIX_BITS-1:0] height;
        logic                present;
    } lrf_cfg_t;

endpackage

@@ rtl/line_rect_fill_rasterizer.sv @@
`timescale 1ns / 1ps

// Point generator for lines, rectangle outlines and filled rectangles on a
// byte-per-pixel frame buffer. A command transaction (line, outline, fill)
// loads the generator and produces no output; every following step
// transaction produces one point until the command is used up, the last one
// flagged with run_done. Commands pass through a two-entry queue to the
// generator, which emits one point per cycle while it walks a segment and the
// output does not stall; the minor axis is tracked with a running remainder,
// so there is no divider. Each new segment (after a line or outline/fill
// command, at every outline corner and at every fill column) passes the
// generator's load states (endpoint ordering, deltas, major axis select),
// while steps wait in the queue. Points are registered in the generator and
// again, with their address (row times pitch plus column), in the output
// register. Points outside the buffer, or with no buffer attached, come out
// with write_enable low and zero fields. The user writes the configuration
// through cfg_write/cfg_index/cfg_data only while idle; it is not enforced.
module line_rect_fill_rasterizer
    import lrf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ADDR_BITS  = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS:0]   end_x_or_width,
    input  logic signed [COORD_BITS:0]   end_y_or_height,
    input  logic [COLOR_BITS-1:0]        pen_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         write_enable,
    output logic [PIX_BITS-1:0]          pixel_x,
    output logic [PIX_BITS-1:0]          pixel_y,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic [COLOR_BITS-1:0]        pixel_value,
    output logic                         run_done
);

    lrf_cfg_t   cfg_reg, cfg_next;
    lrf_head_t  q_head;
    logic signed [COORD_BITS+1:0] q_ax, q_ay, q_bx, q_by;
    logic [COLOR_BITS-1:0]        q_color;
    logic       q_pop;
    logic       pt_valid;
    lrf_point_t pt;
    logic       pt_take;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BUF_WIDTH:   cfg_next.width   = cfg_data;
                REG_BUF_HEIGHT:  cfg_next.height  = cfg_data;
                REG_BUF_PRESENT: cfg_next.present = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width   <= RESET_BUF_WIDTH;
            cfg_reg.height  <= RESET_BUF_HEIGHT;
            cfg_reg.present <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, classify, queue
    lrf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .start_x         (start_x),
        .start_y         (start_y),
        .end_x_or_width  (end_x_or_width),
        .end_y_or_height (end_y_or_height),
        .pen_color       (pen_color),
        .q_head          (q_head),
        .q_ax            (q_ax),
        .q_ay            (q_ay),
        .q_bx            (q_bx),
        .q_by            (q_by),
        .q_color         (q_color),
        .q_pop           (q_pop)
    );

    // Back: segment walker
    lrf_gen #(
        .COORD_BITS (COORD_BITS)
    ) u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_ax     (q_ax),
        .q_ay     (q_ay),
        .q_bx     (q_bx),
        .q_by     (q_by),
        .q_color  (q_color),
        .q_pop    (q_pop),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_take  (pt_take)
    );

    // Address stage and output register
    lrf_pixel #(
        .ADDR_BITS (ADDR_BITS)
    ) u_pixel (
        .clk           (clk),
        .rst_n         (rst_n),
        .buf_width     (cfg_reg.width),
        .pt_valid      (pt_valid),
        .pt            (pt),
        .pt_take       (pt_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_enable  (write_enable),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .run_done      (run_done)
    );

endmodule

@@ rtl/lrf_front.sv @@
`timescale 1ns / 1ps

module lrf_front
    import lrf_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS:0]   end_x_or_width,
    input  logic signed [COORD_BITS:0]   end_y_or_height,
    input  logic [COLOR_BITS-1:0]        pen_color,
    output lrf_head_t                    q_head,
    output logic signed [COORD_BITS+1:0] q_ax,
    output logic signed [COORD_BITS+1:0] q_ay,
    output logic signed [COORD_BITS+1:0] q_bx,
    output logic signed [COORD_BITS+1:0] q_by,
    output logic [COLOR_BITS-1:0]        q_color,
    input  logic                         q_pop
);

    localparam int CW = COORD_BITS + 2;

    lrf_mode_t              in_mode;
    logic signed [CW-1:0]   ax_w;
    logic signed [CW-1:0]   ay_w;
    logic signed [CW-1:0]   ex_w;
    logic signed [CW-1:0]   ey_w;
    logic signed [CW-1:0]   bx_w;
    logic signed [CW-1:0]   by_w;
    logic                   fill_empty;
    logic                   push;

    lrf_mode_t              mode_slot_reg  [QUEUE_DEPTH];
    logic                   empty_slot_reg [QUEUE_DEPTH];
    logic signed [CW-1:0]   ax_slot_reg    [QUEUE_DEPTH];
    logic signed [CW-1:0]   ay_slot_reg    [QUEUE_DEPTH];
    logic signed [CW-1:0]   bx_slot_reg    [QUEUE_DEPTH];
    logic signed [CW-1:0]   by_slot_reg    [QUEUE_DEPTH];
    logic [COLOR_BITS-1:0]  color_slot_reg [QUEUE_DEPTH];

    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    // Classify: a line keeps its end point, a rectangle gets its far corner
    always_comb
    begin
        in_mode    = lrf_mode_t'(mode);
        ax_w       = {{2{start_x[COORD_BITS-1]}}, start_x};
        ay_w       = {{2{start_y[COORD_BITS-1]}}, start_y};
        ex_w       = {end_x_or_width[COORD_BITS], end_x_or_width};
        ey_w       = {end_y_or_height[COORD_BITS], end_y_or_height};
        fill_empty = end_x_or_width[COORD_BITS];
        if (in_mode == MODE_LINE)
        begin
            bx_w = ex_w;
            by_w = ey_w;
        end
        else
        begin
            bx_w = ax_w + ex_w;
            by_w = ay_w + ey_w;
        end
    end

    assign in_stall = (count_reg == QUEUE_FULL);
    assign push     = in_valid && !in_stall;

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mode_slot_reg[wr_ptr_reg]  <= in_mode;
            empty_slot_reg[wr_ptr_reg] <= fill_empty;
            ax_slot_reg[wr_ptr_reg]    <= ax_w;
            ay_slot_reg[wr_ptr_reg]    <= ay_w;
            bx_slot_reg[wr_ptr_reg]    <= bx_w;
            by_slot_reg[wr_ptr_reg]    <= by_w;
            color_slot_reg[wr_ptr_reg] <= pen_color;
        end
    end

    // Head of queue
    always_comb
    begin
        q_head.valid      = (count_reg != '0);
        q_head.mode       = mode_slot_reg[rd_ptr_reg];
        q_head.fill_empty = empty_slot_reg[rd_ptr_reg];
        q_ax              = ax_slot_reg[rd_ptr_reg];
        q_ay              = ay_slot_reg[rd_ptr_reg];
        q_bx              = bx_slot_reg[rd_ptr_reg];
        q_by              = by_slot_reg[rd_ptr_reg];
        q_color           = color_slot_reg[rd_ptr_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_FULL)
        else $error("queue fill level beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

@@ rtl/lrf_gen.sv @@
`timescale 1ns / 1ps

module lrf_gen
    import lrf_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrf_cfg_t                     cfg,
    input  lrf_head_t                    q_head,
    input  logic signed [COORD_BITS+1:0] q_ax,
    input  logic signed [COORD_BITS+1:0] q_ay,
    input  logic signed [COORD_BITS+1:0] q_bx,
    input  logic signed [COORD_BITS+1:0] q_by,
    input  logic [COLOR_BITS-1:0]        q_color,
    output logic                         q_pop,
    output logic                         pt_valid,
    output lrf_point_t                   pt,
    input  logic                         pt_take
);

    localparam int CW   = COORD_BITS + 2;
    localparam int DW   = COORD_BITS + 1;
    localparam int CMPW = (CW > PIX_BITS + 1) ? CW : PIX_BITS + 1;

    lrf_gen_state_t state_reg, state_next;
    logic           busy_reg, busy_next;
    logic           pt_valid_reg, pt_valid_next;
    lrf_point_t     pt_reg;

    lrf_mode_t             kind_reg;
    logic [1:0]            side_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic signed [CW-1:0]  fill_col_reg;
    logic signed [CW-1:0]  cx0_reg, cy0_reg, cx1_reg, cy1_reg;
    logic signed [CW-1:0]  seg_x0_reg, seg_y0_reg, seg_x1_reg, seg_y1_reg;
    logic [DW-1:0]         step_reg, off_reg, rem_reg;
    logic [DW-1:0]         major_reg, minor_reg, dx_reg, dy_reg;
    logic                  xmajor_reg, xinc_reg, yinc_reg;

    logic                  pt_free;
    logic                  do_cmd;
    logic                  do_step;
    logic                  cmd_busy;
    logic                  last;
    logic                  reload;

    logic [DW-1:0]         ox, oy;
    logic signed [CW-1:0]  px, py;
    logic signed [CMPW-1:0] px_c, py_c, wid_c, hgt_c;
    logic                  we;
    lrf_point_t            pt_new;

    logic [DW:0]           rem_sum;
    logic                  rem_wrap;
    logic [DW-1:0]         rem_next;

    logic signed [CW-1:0]  src_x0, src_y0, src_x1, src_y1;
    logic signed [CW-1:0]  ld_x0, ld_y0, ld_x1, ld_y1;

    assign pt_free  = !pt_valid_reg || pt_take;
    assign cmd_busy = !(q_head.mode == MODE_FILL && q_head.fill_empty);

    // Sequencer outputs: pop the queue head when it can be handled
    always_comb
    begin
        q_pop = 1'b0;
        if (state_reg == GEN_IDLE && q_head.valid)
        begin
            if (q_head.mode != MODE_STEP || !busy_reg || pt_free)
            begin
                q_pop = 1'b1;
            end
        end
        do_cmd  = q_pop && q_head.mode != MODE_STEP;
        do_step = q_pop && q_head.mode == MODE_STEP && busy_reg;
    end

    // Segment end: next rectangle side or next fill column
    always_comb
    begin
        last   = (step_reg >= major_reg);
        reload = last && ((kind_reg == MODE_RECT && side_reg != SIDE_LEFT) ||
                          (kind_reg == MODE_FILL && fill_col_reg < cx1_reg));
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GEN_IDLE:
            begin
                if (do_cmd && cmd_busy)
                begin
                    state_next = GEN_SEG;
                end
                else if (do_step && reload)
                begin
                    state_next = GEN_SEG;
                end
            end
            GEN_SEG:   state_next = GEN_DELTA;
            GEN_DELTA: state_next = GEN_MAJOR;
            GEN_MAJOR: state_next = GEN_IDLE;
            default:   state_next = GEN_IDLE;
        endcase
    end

    // Busy flag and point stage valid
    always_comb
    begin
        busy_next = busy_reg;
        if (do_cmd)
        begin
            busy_next = cmd_busy;
        end
        else if (do_step && last && !reload)
        begin
            busy_next = 1'b0;
        end
        pt_valid_next = do_step ? 1'b1 : (pt_take ? 1'b0 : pt_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= GEN_IDLE;
            busy_reg     <= 1'b0;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            pt_valid_reg <= pt_valid_next;
        end
    end

    // Current point and clipping against the buffer
    always_comb
    begin
        ox     = xmajor_reg ? step_reg : off_reg;
        oy     = xmajor_reg ? off_reg : step_reg;
        px     = xinc_reg ? seg_x0_reg + CW'({1'b0, ox}) : seg_x0_reg - CW'({1'b0, ox});
        py     = yinc_reg ? seg_y0_reg + CW'({1'b0, oy}) : seg_y0_reg - CW'({1'b0, oy});
        px_c   = CMPW'(px);
        py_c   = CMPW'(py);
        wid_c  = CMPW'(cfg.width);
        hgt_c  = CMPW'(cfg.height);
        we     = cfg.present && !px_c[CMPW-1] && !py_c[CMPW-1] &&
                 (px_c < wid_c) && (py_c < hgt_c);
        pt_new.we    = we;
        pt_new.x     = we ? px_c[PIX_BITS-1:0] : '0;
        pt_new.y     = we ? py_c[PIX_BITS-1:0] : '0;
        pt_new.color = we ? color_reg : '0;
        pt_new.done  = last && !reload;
    end

    // Incremental remainder for the minor axis
    always_comb
    begin
        rem_sum  = {1'b0, rem_reg} + {1'b0, minor_reg};
        rem_wrap = (rem_sum >= {1'b0, major_reg});
        rem_next = rem_wrap ? DW'(rem_sum - {1'b0, major_reg}) : rem_sum[DW-1:0];
    end

    // Segment source: line ends, a rectangle side, or a fill column
    always_comb
    begin
        src_x0 = seg_x0_reg;
        src_y0 = seg_y0_reg;
        src_x1 = seg_x1_reg;
        src_y1 = seg_y1_reg;
        case (kind_reg)
            MODE_RECT:
            begin
                case (side_reg)
                    SIDE_TOP:
                    begin
                        src_x0 = cx0_reg; src_y0 = cy0_reg;
                        src_x1 = cx1_reg; src_y1 = cy0_reg;
                    end
                    SIDE_RIGHT:
                    begin
                        src_x0 = cx1_reg; src_y0 = cy0_reg;
                        src_x1 = cx1_reg; src_y1 = cy1_reg;
                    end
                    SIDE_BOTTOM:
                    begin
                        src_x0 = cx1_reg; src_y0 = cy1_reg;
                        src_x1 = cx0_reg; src_y1 = cy1_reg;
                    end
                    default:
                    begin
                        src_x0 = cx0_reg; src_y0 = cy1_reg;
                        src_x1 = cx0_reg; src_y1 = cy0_reg;
                    end
                endcase
            end
            MODE_FILL:
            begin
                src_x0 = fill_col_reg; src_y0 = cy0_reg;
                src_x1 = fill_col_reg; src_y1 = cy1_reg;
            end
            default:
            begin
                src_x0 = seg_x0_reg;
                src_y0 = seg_y0_reg;
                src_x1 = seg_x1_reg;
                src_y1 = seg_y1_reg;
            end
        endcase

        // Vertical or horizontal segments run in ascending order
        ld_x0 = src_x0;
        ld_y0 = src_y0;
        ld_x1 = src_x1;
        ld_y1 = src_y1;
        if (src_x0 == src_x1)
        begin
            if (src_y1 < src_y0)
            begin
                ld_y0 = src_y1;
                ld_y1 = src_y0;
            end
        end
        else if (src_y0 == src_y1 && src_x1 < src_x0)
        begin
            ld_x0 = src_x1;
            ld_x1 = src_x0;
        end
    end

    // Generator datapath
    always_ff @(posedge clk)
    begin
        if (do_cmd)
        begin
            kind_reg     <= q_head.mode;
            color_reg    <= q_color;
            side_reg     <= SIDE_TOP;
            fill_col_reg <= q_ax;
            cx0_reg      <= q_ax;
            cy0_reg      <= q_ay;
            cx1_reg      <= q_bx;
            cy1_reg      <= q_by;
            seg_x0_reg   <= q_ax;
            seg_y0_reg   <= q_ay;
            seg_x1_reg   <= q_bx;
            seg_y1_reg   <= q_by;
        end

        if (do_step)
        begin
            pt_reg <= pt_new;
            if (!last)
            begin
                step_reg <= step_reg + 1'b1;
                rem_reg  <= rem_next;
                off_reg  <= off_reg + DW'(rem_wrap);
            end
            else if (reload)
            begin
                if (kind_reg == MODE_RECT)
                begin
                    side_reg <= side_reg + 1'b1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + CW'(1);
                end
            end
        end

        case (state_reg)
            GEN_SEG:
            begin
                seg_x0_reg <= ld_x0;
                seg_y0_reg <= ld_y0;
                seg_x1_reg <= ld_x1;
                seg_y1_reg <= ld_y1;
                step_reg   <= '0;
                rem_reg    <= '0;
                off_reg    <= '0;
            end
            GEN_DELTA:
            begin
                xinc_reg <= (seg_x1_reg > seg_x0_reg);
                yinc_reg <= (seg_y1_reg > seg_y0_reg);
                dx_reg   <= (seg_x1_reg > seg_x0_reg) ? DW'(seg_x1_reg - seg_x0_reg)
                                                      : DW'(seg_x0_reg - seg_x1_reg);
                dy_reg   <= (seg_y1_reg > seg_y0_reg) ? DW'(seg_y1_reg - seg_y0_reg)
                                                      : DW'(seg_y0_reg - seg_y1_reg);
            end
            GEN_MAJOR:
            begin
                xmajor_reg <= (dx_reg > dy_reg);
                major_reg  <= (dx_reg > dy_reg) ? dx_reg : dy_reg;
                minor_reg  <= (dx_reg > dy_reg) ? dy_reg : dx_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    a_no_pop_loading: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != GEN_IDLE |-> !q_pop)
        else $error("queue popped during segment load");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && state_reg == GEN_IDLE |-> step_reg <= major_reg)
        else $error("step count past major delta");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && state_reg == GEN_IDLE && major_reg != '0 |-> rem_reg < major_reg)
        else $error("minor remainder not reduced");

    a_point_held: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid_reg && !pt_take |=> pt_valid_reg && $stable(pt_reg))
        else $error("point stage overwritten before transfer");

endmodule

@@ rtl/lrf_pixel.sv @@
`timescale 1ns / 1ps

module lrf_pixel
    import lrf_pkg::*;
#(
    parameter int ADDR_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PIX_BITS-1:0]   buf_width,
    input  logic                  pt_valid,
    input  lrf_point_t            pt,
    output logic                  pt_take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  write_enable,
    output logic [PIX_BITS-1:0]   pixel_x,
    output logic [PIX_BITS-1:0]   pixel_y,
    output logic [ADDR_BITS-1:0]  pixel_address,
    output logic [COLOR_BITS-1:0] pixel_value,
    output logic                  run_done
);

    localparam int PROD_BITS = 2 * PIX_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    logic                  out_valid_reg, out_valid_next;
    logic                  we_reg;
    logic [PIX_BITS-1:0]   x_reg, y_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [COLOR_BITS-1:0] value_reg;
    logic                  done_reg;
    logic [PROD_BITS-1:0]  prod;
    logic [SUM_BITS-1:0]   addr_sum;

    // Output register frees up when empty or when its transaction completes
    assign pt_take = pt_valid && (!out_valid_reg || !out_stall);

    // Row times pitch plus column
    always_comb
    begin
        prod     = {{PIX_BITS{1'b0}}, pt.y} * {{PIX_BITS{1'b0}}, buf_width};
        addr_sum = {1'b0, prod} + {{(PIX_BITS + 1){1'b0}}, pt.x};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pt_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_take)
        begin
            we_reg    <= pt.we;
            x_reg     <= pt.x;
            y_reg     <= pt.y;
            addr_reg  <= ADDR_BITS'(addr_sum);
            value_reg <= pt.color;
            done_reg  <= pt.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;
    assign run_done      = done_reg;

endmodule
